// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants for the push-to-talk button qualifier.
// Holds the event codes, register indexes, reset values and safety limits.
// Has no dependencies.
package ptt_pkg;

  // Event codes reported once per sample.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_START    = 2'd1,
    EV_TOO_LONG = 2'd2,
    EV_END      = 2'd3
  } event_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_POLL       = 2'd2,
    REG_MAX_RECORD = 2'd3
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [7:0]  DEBOUNCE_RESET   = 8'd30;
  localparam logic [11:0] LONG_PRESS_RESET = 12'd500;
  localparam logic [7:0]  POLL_RESET       = 8'd10;
  localparam logic [15:0] MAX_RECORD_RESET = 16'd60000;

  // Limits of a safe configuration.
  localparam logic [7:0]  DEBOUNCE_MIN     = 8'd10;
  localparam logic [7:0]  DEBOUNCE_MAX     = 8'd200;
  localparam logic [11:0] LONG_PRESS_MIN   = 12'd300;
  localparam logic [11:0] LONG_PRESS_MAX   = 12'd3000;
  localparam logic [15:0] MAX_RECORD_MIN   = 16'd1000;
  localparam logic [15:0] MAX_RECORD_LIMIT = 16'd60000;

endpackage

// ===== rtl/core/push_to_talk_button_qualifier.sv =====
// Push-to-talk button qualifier: debounce and long-press detection.
// One sample in gives one event code out. Depends on ptt_pkg.
//
//   channel   direction  handshake              payload
//   sample    in         samp_valid/samp_stall  raw_level, now_time
//   event     out        evt_valid/evt_stall    event_code
//   config    in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A sample is registered on acceptance, and its event is computed from the
// sample register and registered in the event register once that is free.
// One sample is taken every cycle unless samp_stall holds it; the state update
// of one sample feeds the next through the state registers in the event stage.
// Reset clears valid bits and qualifier state and restores the register defaults.
// A stalled event holds in the output register while the sample register
// still takes one more request. Configuration writes are always ready.
module push_to_talk_button_qualifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          samp_valid,
  output logic                          samp_stall,
  input  logic                          raw_level,
  input  logic [31:0]                   now_time,
  output logic                          evt_valid,
  input  logic                          evt_stall,
  output ptt_pkg::event_t               event_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ptt_pkg::reg_index_t           cfg_index,
  input  logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptt_pkg::*;

  // Configuration registers.
  logic [7:0]  debounce_time;
  logic [11:0] long_press_time;
  logic [7:0]  poll_interval;
  logic [15:0] max_record_time;

  // Sample register.
  logic        s1_valid;
  logic        s1_raw;
  logic [31:0] s1_now;

  // Qualifier state.
  logic        seeded;
  logic        last_raw;
  logic        stable_level;
  logic [31:0] raw_change_time;
  logic [31:0] press_start_time;
  logic [31:0] record_start_time;
  logic        is_recording;
  logic        too_long_sent;

  // Next values.
  logic        cfg_safe;
  logic        last_raw_next;
  logic        stable_level_next;
  logic [31:0] raw_change_time_next;
  logic [31:0] press_start_time_next;
  logic [31:0] record_start_time_next;
  logic        is_recording_next;
  logic        too_long_sent_next;
  logic        seeded_next;
  event_t      event_next;
  logic        settle;
  logic        out_free;
  logic        advance;

  // Elapsed time that counts as zero when the clock runs backwards.
  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] then_t);
    return (now >= then_t) ? (now - then_t) : 32'd0;
  endfunction

  // Pipeline flow: the event register frees when empty or taken.
  assign out_free   = !evt_valid || !evt_stall;
  assign advance    = s1_valid && out_free;
  assign samp_stall = s1_valid && !out_free;
  assign cfg_ready  = 1'b1;

  // Safety check of the configuration.
  always_comb begin
    cfg_safe = 1'b1;
    if (debounce_time < DEBOUNCE_MIN || debounce_time > DEBOUNCE_MAX) cfg_safe = 1'b0;
    if (long_press_time < LONG_PRESS_MIN || long_press_time > LONG_PRESS_MAX) cfg_safe = 1'b0;
    if (long_press_time <= {4'd0, debounce_time}) cfg_safe = 1'b0;
    if (poll_interval == 8'd0 || poll_interval > debounce_time) cfg_safe = 1'b0;
    if (max_record_time < MAX_RECORD_MIN || max_record_time > MAX_RECORD_LIMIT) cfg_safe = 1'b0;
    if (max_record_time <= {4'd0, long_press_time}) cfg_safe = 1'b0;
  end

  // Event logic for the registered sample.
  always_comb begin
    seeded_next            = seeded;
    last_raw_next          = last_raw;
    stable_level_next      = stable_level;
    raw_change_time_next   = raw_change_time;
    press_start_time_next  = press_start_time;
    record_start_time_next = record_start_time;
    is_recording_next      = is_recording;
    too_long_sent_next     = too_long_sent;
    event_next             = EV_NONE;
    settle                 = 1'b0;
    if (cfg_safe) begin
      if (!seeded) begin
        seeded_next           = 1'b1;
        last_raw_next         = s1_raw;
        stable_level_next     = s1_raw;
        raw_change_time_next  = s1_now;
        press_start_time_next = s1_raw ? s1_now : 32'd0;
      end else begin
        // Track the raw edge time.
        last_raw_next = s1_raw;
        if (s1_raw != last_raw) begin
          raw_change_time_next = s1_now;
        end
        // Debounce: follow the raw level once it held long enough.
        settle = (stable_level != s1_raw) &&
                 (since(s1_now, raw_change_time_next) >= {24'd0, debounce_time});
        if (settle) begin
          stable_level_next = s1_raw;
          if (s1_raw) begin
            press_start_time_next = raw_change_time_next;
            too_long_sent_next    = 1'b0;
          end
        end
        // Events in priority order: start, too long, end.
        if (stable_level_next && !is_recording && !too_long_sent_next &&
            since(s1_now, press_start_time_next) >= {20'd0, long_press_time}) begin
          is_recording_next      = 1'b1;
          record_start_time_next = s1_now;
          event_next             = EV_START;
        end else if (stable_level_next && is_recording && !too_long_sent_next &&
                     since(s1_now, record_start_time) >= {16'd0, max_record_time}) begin
          is_recording_next  = 1'b0;
          too_long_sent_next = 1'b1;
          event_next         = EV_TOO_LONG;
        end else if (!stable_level_next) begin
          if (is_recording) begin
            is_recording_next = 1'b0;
            event_next        = EV_END;
          end else begin
            too_long_sent_next = 1'b0;
          end
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
      poll_interval   <= POLL_RESET;
      max_record_time <= MAX_RECORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data[7:0];
        REG_LONG_PRESS: long_press_time <= cfg_data[11:0];
        REG_POLL:       poll_interval   <= cfg_data[7:0];
        REG_MAX_RECORD: max_record_time <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sample register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!samp_stall) begin
      s1_valid <= samp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_valid && !samp_stall) begin
      s1_raw <= raw_level;
      s1_now <= now_time;
    end
  end

  // State and event register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded            <= 1'b0;
      last_raw          <= 1'b0;
      stable_level      <= 1'b0;
      raw_change_time   <= 32'd0;
      press_start_time  <= 32'd0;
      record_start_time <= 32'd0;
      is_recording      <= 1'b0;
      too_long_sent     <= 1'b0;
      evt_valid         <= 1'b0;
      event_code        <= EV_NONE;
    end else begin
      if (out_free) begin
        evt_valid <= s1_valid;
      end
      if (advance) begin
        seeded            <= seeded_next;
        last_raw          <= last_raw_next;
        stable_level      <= stable_level_next;
        raw_change_time   <= raw_change_time_next;
        press_start_time  <= press_start_time_next;
        record_start_time <= record_start_time_next;
        is_recording      <= is_recording_next;
        too_long_sent     <= too_long_sent_next;
        event_code        <= event_next;
      end
    end
  end

`ifndef SYNTHESIS
  // A recording never coexists with a reported too-long.
  a_rec_excl: assert property (@(posedge clk) disable iff (rst)
    !(is_recording && too_long_sent))
    else $error("recording while too-long is flagged");

  // Recording starts only together with a start event.
  a_rec_rise: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $rose(is_recording)) |-> (evt_valid && event_code == EV_START))
    else $error("recording started without a start event");

  // Recording stops only with a too-long or end event.
  a_rec_fall: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $fell(is_recording)) |->
      (evt_valid && (event_code == EV_TOO_LONG || event_code == EV_END)))
    else $error("recording stopped without a too-long or end event");

  // No recording before the state is seeded.
  a_seed: assert property (@(posedge clk) disable iff (rst)
    !seeded |-> !is_recording)
    else $error("recording before seeding");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the push-to-talk button qualifier.
// Predicts one event per accepted sample and compares it with the block's output.
// Depends on ptt_pkg and push_to_talk_button_qualifier.

// Keeps its own copy of the registers and button state, and the queue of pending events.
class event_scoreboard;
  logic [7:0]  debounce_cfg;
  logic [11:0] long_press_cfg;
  logic [7:0]  poll_cfg;
  logic [15:0] max_record_cfg;
  bit          seeded;
  bit          last_raw;
  bit          stable_level;
  bit          is_recording;
  bit          too_long_sent;
  logic [31:0] raw_change_at;
  logic [31:0] press_start_at;
  logic [31:0] record_start_at;
  ptt_pkg::event_t expected_events[$];
  int          errors;

  function new();
    debounce_cfg    = ptt_pkg::DEBOUNCE_RESET;
    long_press_cfg  = ptt_pkg::LONG_PRESS_RESET;
    poll_cfg        = ptt_pkg::POLL_RESET;
    max_record_cfg  = ptt_pkg::MAX_RECORD_RESET;
    seeded          = 1'b0;
    last_raw        = 1'b0;
    stable_level    = 1'b0;
    is_recording    = 1'b0;
    too_long_sent   = 1'b0;
    raw_change_at   = '0;
    press_start_at  = '0;
    record_start_at = '0;
    errors          = 0;
  endfunction

  // Narrow registers keep only their low bits.
  function void apply_write(ptt_pkg::reg_index_t idx, logic [15:0] data);
    case (idx)
      ptt_pkg::REG_DEBOUNCE:   debounce_cfg   = data[7:0];
      ptt_pkg::REG_LONG_PRESS: long_press_cfg = data[11:0];
      ptt_pkg::REG_POLL:       poll_cfg       = data[7:0];
      default:                 max_record_cfg = data;
    endcase
  endfunction

  // Time since a start point; a start in the future counts as no time.
  function logic [31:0] elapsed(logic [31:0] now_t, logic [31:0] from_t);
    return (now_t >= from_t) ? now_t - from_t : 32'd0;
  endfunction

  function bit config_safe();
    if (debounce_cfg < ptt_pkg::DEBOUNCE_MIN || debounce_cfg > ptt_pkg::DEBOUNCE_MAX)
      return 1'b0;
    if (long_press_cfg < ptt_pkg::LONG_PRESS_MIN || long_press_cfg > ptt_pkg::LONG_PRESS_MAX)
      return 1'b0;
    if (long_press_cfg <= debounce_cfg) return 1'b0;
    if (poll_cfg == 0 || poll_cfg > debounce_cfg) return 1'b0;
    if (max_record_cfg < ptt_pkg::MAX_RECORD_MIN || max_record_cfg > ptt_pkg::MAX_RECORD_LIMIT)
      return 1'b0;
    return max_record_cfg > long_press_cfg;
  endfunction

  // Debounces one sample and returns the event it raises.
  function ptt_pkg::event_t qualify_sample(logic raw, logic [31:0] now_t);
    if (!config_safe()) return ptt_pkg::EV_NONE;

    // The first sample only seeds the state.
    if (!seeded) begin
      seeded         = 1'b1;
      last_raw       = raw;
      stable_level   = raw;
      raw_change_at  = now_t;
      press_start_at = raw ? now_t : 32'd0;
      return ptt_pkg::EV_NONE;
    end

    if (raw != last_raw) begin
      last_raw      = raw;
      raw_change_at = now_t;
    end

    // The stable level follows once the raw level has held long enough.
    if (stable_level != last_raw && elapsed(now_t, raw_change_at) >= debounce_cfg) begin
      stable_level = last_raw;
      if (stable_level) begin
        press_start_at = raw_change_at;
        too_long_sent  = 1'b0;
      end
    end

    if (stable_level && !is_recording && !too_long_sent &&
        elapsed(now_t, press_start_at) >= long_press_cfg) begin
      is_recording    = 1'b1;
      record_start_at = now_t;
      return ptt_pkg::EV_START;
    end

    if (stable_level && is_recording && !too_long_sent &&
        elapsed(now_t, record_start_at) >= max_record_cfg) begin
      is_recording  = 1'b0;
      too_long_sent = 1'b1;
      return ptt_pkg::EV_TOO_LONG;
    end

    // A release ends a recording, or else just rearms the too-long report.
    if (!stable_level) begin
      if (is_recording) begin
        is_recording = 1'b0;
        return ptt_pkg::EV_END;
      end
      too_long_sent = 1'b0;
    end
    return ptt_pkg::EV_NONE;
  endfunction

  function void note_sample(logic raw, logic [31:0] now_t);
    expected_events.push_back(qualify_sample(raw, now_t));
  endfunction

  function void check_event(ptt_pkg::event_t got);
    ptt_pkg::event_t want;
    if (expected_events.size() == 0) begin
      errors++;
      $display("%0t: event_code %0d arrived with nothing expected", $time, got);
      return;
    end
    want = expected_events.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: event_code expected %0d, got %0d", $time, want, got);
    end
  endfunction

  function int pending();
    return expected_events.size();
  endfunction
endclass

module testbench;
  import ptt_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASE_ITEMS  = 70;
  localparam int BAD_ITEMS    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        samp_valid = 1'b0;
  logic        samp_stall;
  logic        raw_level = 1'b0;
  logic [31:0] now_time = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  event_t      event_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_index_t  cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  event_scoreboard board = new();

  // Settings the stimulus shapes its timing around.
  int          cur_debounce = 30;
  int          cur_long = 500;
  int          cur_max = 60000;
  logic [31:0] clock_ms = '0;
  int          samples_sent = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;

  push_to_talk_button_qualifier DUT (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .raw_level  (raw_level),
    .now_time   (now_time),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .event_code (event_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none at all while quiet.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Watch every handshake at the rising edge and keep the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.apply_write(cfg_index, cfg_data);
      if (samp_valid && !samp_stall) board.note_sample(raw_level, now_time);
      if (evt_valid && !evt_stall) board.check_event(event_code);
      if ((cfg_valid && cfg_ready) || (samp_valid && !samp_stall) || (evt_valid && !evt_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Event receiver: random stalls, plus one long hold-off on request.
  initial begin : event_sink
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && run_left == 0) begin
        stall_left = pick_gap();
        run_left = $urandom_range(1, 20);
      end
      if (stall_left > 0) begin
        evt_stall <= 1'b1;
        stall_left--;
      end else begin
        evt_stall <= 1'b0;
        run_left--;
      end
    end
  end

  // Offers one sample and returns at the falling edge after it is taken.
  task automatic send_sample(logic lvl, logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samp_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samp_valid <= 1'b1;
    raw_level <= lvl;
    now_time <= t;
    @(posedge clk);
    while (samp_stall) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic advance_send(logic lvl, int dt);
    clock_ms = clock_ms + dt;
    send_sample(lvl, clock_ms);
  endtask

  // Contact bounce that settles on the given level.
  task automatic bounce_to(logic lvl);
    int k;
    k = $urandom_range(0, 3);
    repeat (k) begin
      advance_send(lvl, $urandom_range(0, cur_debounce / 3));
      advance_send(!lvl, $urandom_range(0, cur_debounce / 3));
    end
    advance_send(lvl, $urandom_range(0, cur_debounce / 3));
  endtask

  // A full press: short, long enough to record, or past the record limit.
  task automatic press_episode();
    int hold_ms;
    int n;
    case ($urandom_range(0, 2))
      0: hold_ms = $urandom_range(0, cur_long + cur_debounce);
      1: hold_ms = cur_long + cur_debounce + $urandom_range(0, cur_max);
      default: hold_ms = cur_long + cur_debounce + cur_max + $urandom_range(0, 500);
    endcase
    bounce_to(1'b1);
    n = $urandom_range(2, 8);
    repeat (n) advance_send(1'b1, hold_ms / n + $urandom_range(0, 3));
    bounce_to(1'b0);
    n = $urandom_range(1, 3);
    repeat (n) advance_send(1'b0, (cur_debounce + 10) / n + $urandom_range(0, 20));
  endtask

  // Random level with small steps, backward steps or a jump anywhere.
  task automatic noise_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 3 * cur_debounce);
    else if (r < 85) clock_ms = clock_ms - $urandom_range(1, 2000);
    else clock_ms = $urandom;
    send_sample(1'($urandom_range(0, 1)), clock_ms);
  endtask

  task automatic run_presses(int n);
    int target;
    int r;
    target = samples_sent + n;
    while (samples_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) press_episode();
      else if (r < 85) bounce_to(1'($urandom_range(0, 1)));
      else noise_sample();
    end
  endtask

  // Stop sending and wait until every pending event has been taken.
  task automatic drain();
    samp_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register with random bits above its width.
  task automatic program_reg(reg_index_t idx, int unsigned value);
    logic [15:0] data;
    data = 16'($urandom);
    case (idx)
      REG_DEBOUNCE, REG_POLL: data[7:0] = 8'(value);
      REG_LONG_PRESS:         data[11:0] = 12'(value);
      default:                data = 16'(value);
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(int d, int lp, int pl, int mr);
    drain();
    program_reg(REG_DEBOUNCE, d);
    program_reg(REG_LONG_PRESS, lp);
    program_reg(REG_POLL, pl);
    program_reg(REG_MAX_RECORD, mr);
    cfg_valid <= 1'b0;
    cur_debounce = d;
    cur_long = lp;
    cur_max = mr;
  endtask

  initial begin : stimulus
    logic        dir_level [23] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0,
                                     1, 1, 1, 0, 1, 0, 0, 1, 1, 1, 0};
    logic [31:0] dir_stamp [23] = '{0, 100, 129, 130, 599, 600, 50, 60599, 60600,
                                     61000, 61100, 61130, 61200, 61230, 61700, 61710,
                                     61715, 61800, 61830, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                                     32'h0000_0000, 32'h0000_0001};
    int          bad_cfg [11][4] = '{'{9, 500, 5, 2000}, '{201, 500, 10, 2000},
                                     '{30, 299, 10, 2000}, '{30, 3001, 10, 4000},
                                     '{30, 500, 0, 2000}, '{30, 500, 31, 2000},
                                     '{30, 500, 10, 999}, '{30, 500, 10, 60001},
                                     '{30, 1500, 10, 1500}, '{0, 0, 0, 0},
                                     '{255, 4095, 255, 65535}};
    int          d, lp, pl, lo;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Seeding, debounce, start, backward clock, too-long, end, bounce and clock wrap.
    for (int i = 0; i < 23; i++) send_sample(dir_level[i], dir_stamp[i]);
    clock_ms = dir_stamp[22];

    // Receiver holds off while samples keep coming, so the block backs up.
    quiet = 1'b1;
    hold_off_req = 1'b1;
    repeat (16) noise_sample();
    quiet = 1'b0;

    // Smallest and largest safe settings.
    set_config(10, 300, 1, 1000);
    run_presses(PHASE_ITEMS);
    set_config(200, 3000, 200, 60000);
    run_presses(PHASE_ITEMS);

    // Each safety check failing in turn, plus the field extremes.
    for (int i = 0; i < 11; i++) begin
      set_config(bad_cfg[i][0], bad_cfg[i][1], bad_cfg[i][2], bad_cfg[i][3]);
      run_presses(BAD_ITEMS);
    end

    // Random safe settings, one phase with no idling at all.
    for (int i = 0; i < 6; i++) begin
      d  = $urandom_range(10, 200);
      lp = $urandom_range(300, 3000);
      pl = $urandom_range(1, d);
      lo = (lp < 1000) ? 1000 : lp + 1;
      set_config(d, lp, pl, lo + $urandom_range(0, 4000));
      if ($urandom_range(0, 1)) clock_ms = $urandom;
      quiet = (i == 2);
      run_presses(PHASE_ITEMS);
    end
    quiet = 1'b0;

    drain();
    repeat (8) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
